// File: hdl/page_range_counter_unit_assert.svh
// Assertion macros for the page range counter unit.
// Expects clk and rst_n in the scope of the module that includes this file.
`ifndef PAGE_RANGE_COUNTER_UNIT_ASSERT_SVH
`define PAGE_RANGE_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/prc_pkg.sv
// Shared constants, codes and structs of the page range counter.
// No dependencies; imported by prc_close, page_range_counter_unit and the testbench.
`default_nettype none

package prc_pkg;

  localparam int NUM_W = 16;
  localparam int CNT_W = 24;

  localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [1:0] DC_ZERO = 2'd0;
  localparam logic [1:0] DC_ONE  = 2'd1;
  localparam logic [1:0] DC_TWO  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADCHAR = 3'd1,
    ST_FORMAT  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_DESCEND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CLS_START = 2'd0,
    CLS_DIGIT = 2'd1,
    CLS_DASH  = 2'd2,
    CLS_COMMA = 2'd3
  } cls_t;

  typedef struct packed {
    logic [NUM_W-1:0] acc;
    logic [NUM_W-1:0] start;
    logic [1:0]       dash_count;
    status_t          seg_err;
    logic [CNT_W-1:0] total;
  } seg_t;

  typedef struct packed {
    status_t          seg_err;
    logic [CNT_W-1:0] total;
  } close_t;

endpackage

`default_nettype wire

// File: hdl/prc_close.sv
// Segment close evaluator: range, order and dash-count checks and saturating page accumulation.
// Depends on prc_pkg.
`default_nettype none

module prc_close (
  input  prc_pkg::seg_t            seg_i,
  input  logic [prc_pkg::NUM_W-1:0] total_pages,
  output prc_pkg::close_t          close_o
);
  import prc_pkg::*;

  logic [NUM_W-1:0] diff;
  logic [NUM_W:0]   n_pages;
  logic [CNT_W:0]   sum;
  logic             do_add;
  logic             acc_bad;

  assign diff    = seg_i.acc - seg_i.start;
  assign acc_bad = (seg_i.acc == '0) || (seg_i.acc > total_pages);

  always_comb begin
    close_o.seg_err = seg_i.seg_err;
    do_add          = 1'b0;
    n_pages         = {{NUM_W{1'b0}}, 1'b1};
    if (seg_i.seg_err == ST_OK) begin
      case (seg_i.dash_count)
        DC_ZERO: begin
          if (acc_bad) close_o.seg_err = ST_RANGE;
          else do_add = 1'b1;
        end
        DC_ONE: begin
          if (seg_i.start == '0) close_o.seg_err = ST_RANGE;
          else if (acc_bad) close_o.seg_err = ST_RANGE;
          else if (seg_i.start > seg_i.acc) close_o.seg_err = ST_DESCEND;
          else begin
            do_add  = 1'b1;
            n_pages = {1'b0, diff} + {{NUM_W{1'b0}}, 1'b1};
          end
        end
        default: close_o.seg_err = ST_FORMAT;
      endcase
    end
  end

  assign sum = {1'b0, seg_i.total} + {{(CNT_W-NUM_W){1'b0}}, n_pages};

  always_comb begin
    close_o.total = seg_i.total;
    if (do_add) close_o.total = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  end

endmodule

`default_nettype wire

// File: hdl/page_range_counter_unit.sv
// Page range counter: parses a page selection string one character per transfer.
// The last character is held in the input register, then its result in the result register.
// Throughput: 1 character per cycle, set by the combinational digit multiply-add and segment
// close path between the two registers; a last character waits while a result is not yet taken.
// Reset (rst_n low, synchronous): clears string state, valid flags, total_pages.
// Depends on prc_pkg, prc_close and page_range_counter_unit_assert.svh.
`default_nettype none
`include "page_range_counter_unit_assert.svh"

module page_range_counter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,   // total_pages
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [23:0] page_count, [26:24] status, rest zero
);
  import prc_pkg::*;

  logic [NUM_W-1:0] tp_r;

  logic             in_valid_r, in_valid_nxt;
  logic [7:0]       in_char_r;
  logic             in_last_r;

  logic [NUM_W-1:0] acc_r, acc_nxt;
  logic [NUM_W-1:0] start_r, start_nxt;
  logic [1:0]       dc_r, dc_nxt;
  status_t          seg_err_r, seg_err_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic             bad_char_r, bad_char_nxt;
  logic             bad_form_r, bad_form_nxt;
  cls_t             prev_r, prev_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;
  status_t          out_status_r, out_status_nxt;

  logic             proc_fire;
  logic             is_digit, is_dash, is_comma, is_sep;
  logic [NUM_W+3:0] mac;
  logic [NUM_W-1:0] acc_dig;
  seg_t             mid;
  close_t           closed;
  logic             do_close;
  status_t          fin_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) tp_r <= '0;
    else if (cfg_valid && cfg_ready) tp_r <= cfg_data;
  end

  assign proc_fire = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_fire;
  assign in_valid_nxt = in_tready ? in_tvalid : in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) in_valid_r <= 1'b0;
    else in_valid_r <= in_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  assign is_digit = in_char_r inside {[CH_ZERO:CH_NINE]};
  assign is_dash  = (in_char_r == CH_DASH);
  assign is_comma = (in_char_r == CH_COMMA);
  assign is_sep   = is_dash || is_comma;

  assign mac = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
             + {{NUM_W{1'b0}}, in_char_r[3:0]};
  assign acc_dig = (mac[NUM_W+3:NUM_W] != 4'd0) ? NUM_MAX : mac[NUM_W-1:0];

  always_comb begin
    mid.acc        = acc_r;
    mid.start      = start_r;
    mid.dash_count = dc_r;
    mid.seg_err    = seg_err_r;
    mid.total      = total_r;
    bad_char_nxt   = bad_char_r;
    bad_form_nxt   = bad_form_r;
    prev_nxt       = prev_r;
    if (is_digit) begin
      mid.acc  = acc_dig;
      prev_nxt = CLS_DIGIT;
    end else if (is_sep) begin
      if (prev_r != CLS_DIGIT) bad_form_nxt = 1'b1;
      if (is_dash) begin
        if (dc_r == DC_ZERO) begin
          mid.start      = acc_r;
          mid.acc        = '0;
          mid.dash_count = DC_ONE;
        end else begin
          mid.dash_count = DC_TWO;
        end
        prev_nxt = CLS_DASH;
      end else begin
        prev_nxt = CLS_COMMA;
      end
    end else begin
      bad_char_nxt = 1'b1;
    end
  end

  prc_close u_close (
    .seg_i       (mid),
    .total_pages (tp_r),
    .close_o     (closed)
  );

  assign do_close = is_comma || (in_last_r && !is_sep);

  always_comb begin
    acc_nxt     = mid.acc;
    start_nxt   = mid.start;
    dc_nxt      = mid.dash_count;
    seg_err_nxt = mid.seg_err;
    total_nxt   = mid.total;
    if (do_close) begin
      acc_nxt     = '0;
      start_nxt   = '0;
      dc_nxt      = DC_ZERO;
      seg_err_nxt = closed.seg_err;
      total_nxt   = closed.total;
    end
  end

  always_comb begin
    if (bad_char_nxt) fin_status = ST_BADCHAR;
    else if (bad_form_nxt || !is_digit) fin_status = ST_FORMAT;
    else fin_status = seg_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      start_r    <= '0;
      dc_r       <= DC_ZERO;
      seg_err_r  <= ST_OK;
      total_r    <= '0;
      bad_char_r <= 1'b0;
      bad_form_r <= 1'b0;
      prev_r     <= CLS_START;
    end else if (proc_fire) begin
      if (in_last_r) begin
        acc_r      <= '0;
        start_r    <= '0;
        dc_r       <= DC_ZERO;
        seg_err_r  <= ST_OK;
        total_r    <= '0;
        bad_char_r <= 1'b0;
        bad_form_r <= 1'b0;
        prev_r     <= CLS_START;
      end else begin
        acc_r      <= acc_nxt;
        start_r    <= start_nxt;
        dc_r       <= dc_nxt;
        seg_err_r  <= seg_err_nxt;
        total_r    <= total_nxt;
        bad_char_r <= bad_char_nxt;
        bad_form_r <= bad_form_nxt;
        prev_r     <= prev_nxt;
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    if (proc_fire && in_last_r) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fin_status;
      out_count_nxt  = (fin_status == ST_OK) ? total_nxt : '0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_status_r, out_count_r};

  `PRC_ASSERT_NOW(a_err_zero_count, out_valid_r && (out_status_r != ST_OK),
    out_count_r == '0, "page count nonzero with error status")
  `PRC_ASSERT_NOW(a_status_legal, out_valid_r,
    (out_status_r == ST_OK) || (out_status_r == ST_BADCHAR) ||
    (out_status_r == ST_FORMAT) || (out_status_r == ST_RANGE) ||
    (out_status_r == ST_DESCEND), "illegal status code")
  `PRC_ASSERT_NEXT(a_clear_after_last, proc_fire && in_last_r,
    (acc_r == '0) && (dc_r == DC_ZERO) && (total_r == '0) && !bad_char_r && !bad_form_r,
    "string state not cleared after last character")
  `PRC_ASSERT_NOW(a_start_needs_dash, dc_r == DC_ZERO, start_r == '0,
    "range start held without a dash")

endmodule

`default_nettype wire

// File: dv/page_range_counter_unit_test.sv
// Self-checking testbench for page_range_counter_unit: streams page selection strings,
// predicts each page count and status, and compares every result transfer.
// Depends on prc_pkg and the page_range_counter_unit RTL.
module page_range_counter_unit_test;
  import prc_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_CHARS = 460;

  typedef struct {
    logic [23:0] pages;
    status_t     status;
  } tally_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  page_range_counter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predicted parser state
  logic [15:0] total_pages;
  logic [15:0] num_acc;
  logic [15:0] first_page;
  logic [1:0]  dashes;
  status_t     seg_status;
  logic [23:0] page_total;
  logic        bad_char;
  logic        bad_form;
  cls_t        prev_cls;

  tally_t      expected_tallies[$];
  logic [7:0]  text_chars[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          chars_sent;
  int          mismatches;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_string();
    num_acc    = '0;
    first_page = '0;
    dashes     = DC_ZERO;
    seg_status = ST_OK;
    page_total = '0;
    bad_char   = 1'b0;
    bad_form   = 1'b0;
    prev_cls   = CLS_START;
  endfunction

  function automatic void add_pages(logic [16:0] n);
    logic [24:0] sum;
    sum = {1'b0, page_total} + {8'd0, n};
    page_total = (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[23:0];
  endfunction

  function automatic void close_segment();
    if (seg_status == ST_OK) begin
      if (dashes == DC_ZERO) begin
        if (num_acc == 0 || num_acc > total_pages) seg_status = ST_RANGE;
        else add_pages(17'd1);
      end else if (dashes == DC_ONE) begin
        if (first_page == 0 || num_acc == 0 || num_acc > total_pages) seg_status = ST_RANGE;
        else if (first_page > num_acc) seg_status = ST_DESCEND;
        else add_pages({1'b0, num_acc} - {1'b0, first_page} + 17'd1);
      end else begin
        seg_status = ST_FORMAT;
      end
    end
    num_acc    = '0;
    first_page = '0;
    dashes     = DC_ZERO;
  endfunction

  function automatic void tally_char(logic [7:0] c, logic last);
    logic        is_digit;
    logic        is_sep;
    int unsigned v;
    status_t     st;
    tally_t      t;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_sep   = (c == CH_DASH) || (c == CH_COMMA);
    if (is_digit) begin
      v = 32'(num_acc) * 10 + 32'(c - CH_ZERO);
      num_acc  = (v > 32'(NUM_MAX)) ? NUM_MAX : v[15:0];
      prev_cls = CLS_DIGIT;
    end else if (is_sep) begin
      if (prev_cls != CLS_DIGIT) bad_form = 1'b1;
      if (c == CH_DASH) begin
        if (dashes == DC_ZERO) begin
          first_page = num_acc;
          num_acc    = '0;
          dashes     = DC_ONE;
        end else begin
          dashes = DC_TWO;
        end
        prev_cls = CLS_DASH;
      end else begin
        close_segment();
        prev_cls = CLS_COMMA;
      end
    end else begin
      bad_char = 1'b1;
    end
    if (last) begin
      if (!is_digit) bad_form = 1'b1;
      if (!is_sep) close_segment();
      if (bad_char) st = ST_BADCHAR;
      else if (bad_form) st = ST_FORMAT;
      else st = seg_status;
      t.pages  = (st == ST_OK) ? page_total : 24'd0;
      t.status = st;
      expected_tallies.push_back(t);
      clear_string();
    end
  endfunction

  // sender: returns just after the posedge of the transfer
  task automatic send_char(logic [7:0] c, logic last);
    @(negedge clk);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    tally_char(c, last);
    chars_sent++;
  endtask

  task automatic send_text(string s, logic ends);
    for (int i = 0; i < s.len(); i++) send_char(s[i], ends && (i == s.len() - 1));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_tallies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_total(logic [15:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    total_pages = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void append_number(int unsigned v);
    logic [7:0] digits[$];
    int         zeros;
    zeros = ($urandom_range(99) < 15) ? $urandom_range(1, 2) : 0;
    do begin
      digits.push_front(CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    repeat (zeros) digits.push_front(CH_ZERO);
    foreach (digits[i]) text_chars.push_back(digits[i]);
  endfunction

  function automatic int unsigned pick_page();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 70) return $urandom_range(1, (total_pages == 0) ? 1 : total_pages);
    if (r < 80) return 32'(total_pages) + $urandom_range(1, 10);
    if (r < 92) return $urandom_range(0, 99999);
    return $urandom_range(65530, 999999);
  endfunction

  task automatic send_random_text();
    int          nseg;
    int unsigned a;
    int unsigned b;
    int unsigned tmp;
    int          pos;
    text_chars.delete();
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(1, 5)) text_chars.push_back(8'($urandom_range(255)));
    end else begin
      nseg = $urandom_range(1, 4);
      for (int s = 0; s < nseg; s++) begin
        if (s > 0) text_chars.push_back(CH_COMMA);
        a = pick_page();
        if ($urandom_range(1) == 1) begin
          b = pick_page();
          if (a > b && $urandom_range(99) < 70) begin
            tmp = a;
            a   = b;
            b   = tmp;
          end
          append_number(a);
          text_chars.push_back(CH_DASH);
          append_number(b);
        end else begin
          append_number(a);
        end
      end
      if ($urandom_range(99) < 15) begin
        pos = $urandom_range(text_chars.size() - 1);
        case ($urandom_range(3))
          0: text_chars[pos] = 8'($urandom_range(255));
          1: text_chars.insert(pos, ($urandom_range(1) == 1) ? CH_DASH : CH_COMMA);
          2: if (text_chars.size() > 1) void'(text_chars.pop_back());
          default: text_chars.push_back(($urandom_range(1) == 1) ? CH_DASH : CH_COMMA);
        endcase
      end
    end
    foreach (text_chars[i]) send_char(text_chars[i], i == text_chars.size() - 1);
  endtask

  task automatic run_random_phase(int send_pct, int stall_pct, logic [15:0] limit);
    int first_char;
    set_total(limit);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    first_char = chars_sent;
    while (chars_sent - first_char < PHASE_CHARS) send_random_text();
    wait_drained();
  endtask

  task automatic test_single_pages();
    set_total(16'd10);
    send_text("0", 1'b1);
    send_text("9", 1'b1);
    send_text("11", 1'b1);
  endtask

  task automatic test_ranges();
    send_text("3-7,10", 1'b1);
    send_text("0-3", 1'b1);
    send_text("2-0", 1'b1);
    send_text("2-11", 1'b1);
    send_text("4-2,0", 1'b1);
    send_text("1-2-3", 1'b1);
  endtask

  task automatic test_format_errors();
    send_text(",1", 1'b1);
    send_text("1,,2", 1'b1);
    send_text("5-", 1'b1);
  endtask

  task automatic test_bad_chars();
    send_char(8'h00, 1'b0);
    send_char(CH_DASH, 1'b1);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_total_extremes();
    set_total(16'd0);
    send_text("1", 1'b1);
    set_total(16'hFFFF);
    send_text("99999", 1'b1);
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 16'hFFFF);
    run_random_phase(71, 0, 16'd1);
    run_random_phase(0, 71, 16'($urandom_range(2, 40)));
    run_random_phase(30, 30, 16'($urandom_range(0, 65535)));
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    tally_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_tallies.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_tallies.pop_front();
          if (out_tdata[23:0] !== want.pages) begin
            $display("%0t: page_count expected %0d actual %0d", $time, want.pages,
                     out_tdata[23:0]);
            mismatches++;
          end
          if (out_tdata[26:24] !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_tdata[26:24]);
            mismatches++;
          end
          if (out_tdata[31:27] !== 5'd0) begin
            $display("%0t: pad bits expected 0 actual %h", $time, out_tdata[31:27]);
            mismatches++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("page_range_counter_unit test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    chars_sent     = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    total_pages    = '0;
    clear_string();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_single_pages();
    test_ranges();
    test_format_errors();
    test_bad_chars();
    test_total_extremes();
    test_random_traffic();
    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && expected_tallies.size() == 0)
      $display("page_range_counter_unit test passed");
    else
      $display("page_range_counter_unit test failed");
    $finish;
  end

endmodule
